### hdl/usc_pkg.sv
package usc_pkg;

    localparam int UNIX_W = 32;
    localparam int ZONE_W = 17;
    localparam int YEAR_W = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int HOUR_W = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int PIPE_DEPTH = 8;

    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam int DAY_RECIP_SHIFT = 35;
    localparam logic [9:0] DAY_DIV_HI = 10'd675;

    localparam logic [19:0] MARCH_SHIFT = 20'd719468;
    localparam logic [19:0] ERA5_START = 20'd730485;
    localparam logic [19:0] ERA4_START = 20'd584388;
    localparam logic [11:0] ERA4_YEAR = 12'd1600;
    localparam logic [11:0] ERA5_YEAR = 12'd2000;

    localparam logic [17:0] RECIP_1460 = 18'd183860;
    localparam int RECIP_1460_SHIFT = 28;
    localparam logic [17:0] RECIP_365 = 18'd183860;
    localparam int RECIP_365_SHIFT = 26;
    localparam logic [17:0] CENTURY_DAYS = 18'd36524;
    localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
    localparam logic [17:0] YEAR_DAYS = 18'd365;

    localparam logic [17:0] RECIP_60_SOD = 18'd139811;
    localparam int RECIP_60_SOD_SHIFT = 23;
    localparam logic [11:0] RECIP_60_MIN = 12'd2185;
    localparam int RECIP_60_MIN_SHIFT = 17;
    localparam logic [5:0] SIXTY = 6'd60;

    localparam logic [3:0] MARCH_MONTHS = 4'd11;
    localparam logic [3:0] MP_JANUARY = 4'd10;

    // First day of year (March based) of each month, index 0 is March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0: start = 9'd0;
            4'd1: start = 9'd31;
            4'd2: start = 9'd61;
            4'd3: start = 9'd92;
            4'd4: start = 9'd122;
            4'd5: start = 9'd153;
            4'd6: start = 9'd184;
            4'd7: start = 9'd214;
            4'd8: start = 9'd245;
            4'd9: start = 9'd275;
            4'd10: start = 9'd306;
            4'd11: start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

### hdl/unix_seconds_to_calendar.sv
// Converts a 32-bit Unix second count, shifted by the signed zone offset register, into the
// Gregorian year, month, day, hour, minute and second. The block is an eight-stage pipeline
// that takes one transaction in every cycle while the input is not stalled; the depth is
// set by the chain of constant reciprocal multipliers, each followed by a register. A stall
// on the output holds the last stage, and earlier stages keep filling any empty slots
// before the input is stalled.
// The zone offset should be written only while no transaction is in flight.
module unix_seconds_to_calendar (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [usc_pkg::ZONE_W-1:0]     i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [usc_pkg::UNIX_W-1:0]     i_unix_seconds,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [usc_pkg::YEAR_W-1:0]     o_year,
    output logic [usc_pkg::MONTH_W-1:0]    o_month,
    output logic [usc_pkg::DAY_W-1:0]      o_day_of_month,
    output logic [usc_pkg::HOUR_W-1:0]     o_hour,
    output logic [usc_pkg::MINUTE_W-1:0]   o_minute,
    output logic [usc_pkg::SECOND_W-1:0]   o_second
);

    logic [usc_pkg::ZONE_W-1:0] r_zone;
    logic [usc_pkg::PIPE_DEPTH-1:0] r_v;
    logic [usc_pkg::PIPE_DEPTH-1:0] w_en;

    logic [31:0] r1_t;

    logic [50:0] r2_prod;
    logic [24:0] r2_x;
    logic [6:0]  r2_lo;

    logic [15:0] r3_days;
    logic [16:0] r3_sod;

    logic [17:0] r4_doe;
    logic        r4_era5;
    logic [16:0] r4_sod;
    logic [34:0] r4_tprod;

    logic [17:0] r5_doe;
    logic        r5_era5;
    logic [35:0] r5_qprod;
    logic [2:0]  r5_cent;
    logic        r5_last;
    logic [10:0] r5_tm;
    logic [5:0]  r5_sec;

    logic [17:0] r6_doe;
    logic        r6_era5;
    logic [35:0] r6_yprod;
    logic [22:0] r6_hprod;
    logic [10:0] r6_tm;
    logic [5:0]  r6_sec;

    logic [8:0]  r7_doy;
    logic [8:0]  r7_yoe;
    logic        r7_era5;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;

    logic [31:0] n_t;
    logic [15:0] n_days;
    logic [24:0] n_rem;
    logic [19:0] n_z;
    logic        n_era5;
    logic [19:0] n_doe;
    logic [16:0] n_sec_full;
    logic [2:0]  n_cent;
    logic [6:0]  n_q1460;
    logic [17:0] n_yn;
    logic [8:0]  n_yoe;
    logic [1:0]  n_c100;
    logic [17:0] n_doy;
    logic [4:0]  n_hour;
    logic [10:0] n_min_full;
    logic [3:0]  n_mp;
    logic [8:0]  n_day_full;

    always_comb begin
        w_en[usc_pkg::PIPE_DEPTH-1] = !r_v[usc_pkg::PIPE_DEPTH-1] || !i_stall;
        for (int k = usc_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[usc_pkg::PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
            r_v <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_zone <= i_cfg_wr_data;
            end
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < usc_pkg::PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: apply the zone offset.
    assign n_t = i_unix_seconds + {{(32 - usc_pkg::ZONE_W){r_zone[usc_pkg::ZONE_W-1]}}, r_zone};

    // Stage 3: days and second of day from the reciprocal product.
    assign n_days = r2_prod[50:usc_pkg::DAY_RECIP_SHIFT];
    assign n_rem = r2_x - 25'(n_days) * 25'(usc_pkg::DAY_DIV_HI);

    // Stage 4: March-based day number, era and day of era.
    assign n_z = 20'(r3_days) + usc_pkg::MARCH_SHIFT;
    assign n_era5 = n_z >= usc_pkg::ERA5_START;
    assign n_doe = n_z - (n_era5 ? usc_pkg::ERA5_START : usc_pkg::ERA4_START);

    // Stage 5: seconds, century count.
    assign n_sec_full = r4_sod - 17'(r4_tprod[33:usc_pkg::RECIP_60_SOD_SHIFT]) * 17'(usc_pkg::SIXTY);
    assign n_cent = 3'(r4_doe >= usc_pkg::CENTURY_DAYS)
                  + 3'(r4_doe >= 18'(2 * usc_pkg::CENTURY_DAYS))
                  + 3'(r4_doe >= 18'(3 * usc_pkg::CENTURY_DAYS))
                  + 3'(r4_doe >= usc_pkg::ERA_LAST_DAY);

    // Stage 6: leap-corrected day count ahead of the division by 365.
    assign n_q1460 = r5_qprod[34:usc_pkg::RECIP_1460_SHIFT];
    assign n_yn = r5_doe - 18'(n_q1460) + 18'(r5_cent) - 18'(r5_last);

    // Stage 7: year of era, day of year, hour and minute.
    assign n_yoe = r6_yprod[34:usc_pkg::RECIP_365_SHIFT];
    assign n_c100 = 2'(n_yoe >= 9'd100) + 2'(n_yoe >= 9'd200) + 2'(n_yoe >= 9'd300);
    assign n_doy = r6_doe - (18'(n_yoe) * usc_pkg::YEAR_DAYS + 18'(n_yoe[8:2]) - 18'(n_c100));
    assign n_hour = r6_hprod[21:usc_pkg::RECIP_60_MIN_SHIFT];
    assign n_min_full = r6_tm - 11'(n_hour) * 11'(usc_pkg::SIXTY);

    // Stage 8: month from the table of month starts.
    always_comb begin
        n_mp = '0;
        for (int k = 1; k <= int'(usc_pkg::MARCH_MONTHS); k++) begin
            if (r7_doy >= usc_pkg::month_start(4'(k))) begin
                n_mp = 4'(k);
            end
        end
    end

    assign n_day_full = r7_doy - usc_pkg::month_start(n_mp) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_t <= n_t;
        end
        if (w_en[1]) begin
            r2_prod <= 51'(r1_t[31:7]) * 51'(usc_pkg::DAY_RECIP);
            r2_x <= r1_t[31:7];
            r2_lo <= r1_t[6:0];
        end
        if (w_en[2]) begin
            r3_days <= n_days;
            r3_sod <= {n_rem[9:0], r2_lo};
        end
        if (w_en[3]) begin
            r4_doe <= n_doe[17:0];
            r4_era5 <= n_era5;
            r4_sod <= r3_sod;
            r4_tprod <= 35'(r3_sod) * 35'(usc_pkg::RECIP_60_SOD);
        end
        if (w_en[4]) begin
            r5_doe <= r4_doe;
            r5_era5 <= r4_era5;
            r5_qprod <= 36'(r4_doe) * 36'(usc_pkg::RECIP_1460);
            r5_cent <= n_cent;
            r5_last <= r4_doe >= usc_pkg::ERA_LAST_DAY;
            r5_tm <= r4_tprod[33:usc_pkg::RECIP_60_SOD_SHIFT];
            r5_sec <= n_sec_full[5:0];
        end
        if (w_en[5]) begin
            r6_doe <= r5_doe;
            r6_era5 <= r5_era5;
            r6_yprod <= 36'(n_yn) * 36'(usc_pkg::RECIP_365);
            r6_hprod <= 23'(r5_tm) * 23'(usc_pkg::RECIP_60_MIN);
            r6_tm <= r5_tm;
            r6_sec <= r5_sec;
        end
        if (w_en[6]) begin
            r7_doy <= n_doy[8:0];
            r7_yoe <= n_yoe;
            r7_era5 <= r6_era5;
            r7_hour <= n_hour;
            r7_min <= n_min_full[5:0];
            r7_sec <= r6_sec;
        end
        if (w_en[7]) begin
            o_year <= 12'(r7_yoe) + (r7_era5 ? usc_pkg::ERA5_YEAR : usc_pkg::ERA4_YEAR)
                    + 12'(n_mp >= usc_pkg::MP_JANUARY);
            o_month <= (n_mp < usc_pkg::MP_JANUARY) ? n_mp + 4'd3 : n_mp - 4'd9;
            o_day_of_month <= n_day_full[4:0];
            o_hour <= r7_hour;
            o_minute <= r7_min;
            o_second <= r7_sec;
        end
    end

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month != 5'd0))
        else $error("Result month or day out of range.");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59))
        else $error("Result time of day out of range.");

    a_held_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && !w_en[6]) |=> r_v[6])
        else $error("A held transaction left the pipeline.");

    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en[0] |-> (&r_v))
        else $error("Input stalled while the pipeline had a free slot.");

endmodule
